FILE: rtl/vital_sign_smoothing_filter_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the vital sign smoothing filter
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef VITAL_SIGN_SMOOTHING_FILTER_MACROS_SVH
`define VITAL_SIGN_SMOOTHING_FILTER_MACROS_SVH

// Same-cycle implication
`define VSSF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vssf: same-cycle check failed");

// Next-cycle implication
`define VSSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vssf: next-cycle check failed");

`endif

FILE: rtl/vssf_pkg.sv
// ---------------------------------------------------------------------------
// Vital sign smoothing filter package
// Field widths, register reset values, register indexes and shared structs.
// ---------------------------------------------------------------------------
package vssf_pkg;

	localparam int unsigned HR_W   = 8;
	localparam int unsigned SPO2_W = 10;
	localparam int unsigned VAL_W  = 11;
	localparam int unsigned DEC_W  = 4;
	localparam int unsigned TMO_W  = 3;
	localparam int unsigned RUN_W  = 3;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned DATA_W = 10;

	// Jump rejection
	localparam int unsigned JUMP_LIMIT    = 10;
	localparam int unsigned RUN_FOR_CHECK = 4;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_HR_MIN_VALID   = 3'd0,
		CFG_HR_MAX_VALID   = 3'd1,
		CFG_SPO2_MIN_VALID = 3'd2,
		CFG_DECIMATE_COUNT = 3'd3,
		CFG_TIMEOUT_LIMIT  = 3'd4,
		CFG_HR_ALARM_MAX   = 3'd5,
		CFG_SPO2_ALARM_MIN = 3'd6,
		CFG_SPO2_ALARM_MAX = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [HR_W-1:0]   hr_min_valid;
		logic [HR_W-1:0]   hr_max_valid;
		logic [SPO2_W-1:0] spo2_min_valid;
		logic [DEC_W-1:0]  decimate_count;
		logic [TMO_W-1:0]  timeout_limit;
		logic [HR_W-1:0]   hr_alarm_max;
		logic [SPO2_W-1:0] spo2_alarm_min;
		logic [SPO2_W-1:0] spo2_alarm_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		hr_min_valid:   8'd60,
		hr_max_valid:   8'd150,
		spo2_min_valid: 10'd70,
		decimate_count: 4'd10,
		timeout_limit:  3'd4,
		hr_alarm_max:   8'd120,
		spo2_alarm_min: 10'd80,
		spo2_alarm_max: 10'd100
	};

	// Per-channel update control
	typedef struct packed {
		logic enable;
		logic good;
	} chan_ctl_t;

endpackage

FILE: rtl/vssf_cfg.sv
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the eight filter registers, written through a valid/ready channel.
// ---------------------------------------------------------------------------
module vssf_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [vssf_pkg::IDX_W-1:0]       cfg_index,
	input  logic [vssf_pkg::DATA_W-1:0]      cfg_data,
	output vssf_pkg::cfg_t                   cfg
);

	vssf_pkg::cfg_t cfg_q;

	// Take every write transaction at once
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= vssf_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (vssf_pkg::cfg_idx_t'(cfg_index))
				vssf_pkg::CFG_HR_MIN_VALID: begin
					cfg_q.hr_min_valid <= cfg_data[vssf_pkg::HR_W-1:0];
				end
				vssf_pkg::CFG_HR_MAX_VALID: begin
					cfg_q.hr_max_valid <= cfg_data[vssf_pkg::HR_W-1:0];
				end
				vssf_pkg::CFG_SPO2_MIN_VALID: begin
					cfg_q.spo2_min_valid <= cfg_data[vssf_pkg::SPO2_W-1:0];
				end
				vssf_pkg::CFG_DECIMATE_COUNT: begin
					cfg_q.decimate_count <= cfg_data[vssf_pkg::DEC_W-1:0];
				end
				vssf_pkg::CFG_TIMEOUT_LIMIT: begin
					cfg_q.timeout_limit <= cfg_data[vssf_pkg::TMO_W-1:0];
				end
				vssf_pkg::CFG_HR_ALARM_MAX: begin
					cfg_q.hr_alarm_max <= cfg_data[vssf_pkg::HR_W-1:0];
				end
				vssf_pkg::CFG_SPO2_ALARM_MIN: begin
					cfg_q.spo2_alarm_min <= cfg_data[vssf_pkg::SPO2_W-1:0];
				end
				vssf_pkg::CFG_SPO2_ALARM_MAX: begin
					cfg_q.spo2_alarm_max <= cfg_data[vssf_pkg::SPO2_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

FILE: rtl/vssf_channel.sv
// ---------------------------------------------------------------------------
// Smoothing channel
// Jump rejection, history shift line, adder tree mean and miss timeout.
// ---------------------------------------------------------------------------
`include "vital_sign_smoothing_filter_macros.svh"

module vssf_channel #(
	parameter int unsigned W      = 8,
	parameter int unsigned DEPTH  = 16,
	parameter bit          UPWARD = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vssf_pkg::chan_ctl_t          ctl,
	input  logic [W-1:0]                 value,
	input  logic [vssf_pkg::TMO_W-1:0]   timeout_limit,
	output logic [W-1:0]                 avg_next
);

	localparam int unsigned FILL_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W  = W + $clog2(DEPTH);
	localparam int unsigned RUN_W  = vssf_pkg::RUN_W;
	localparam logic [RUN_W-1:0] RUN_CHECK = RUN_W'(vssf_pkg::RUN_FOR_CHECK);
	localparam logic [W:0]       JUMP      = (W+1)'(vssf_pkg::JUMP_LIMIT);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

	logic [W-1:0]      hist_q [DEPTH];
	logic [FILL_W-1:0] fill_q;
	logic [RUN_W-1:0]  vrun_q;
	logic [vssf_pkg::TMO_W-1:0] mrun_q;
	logic [W-1:0]      avg_q;

	logic [W-1:0]      hist_n [DEPTH];
	logic [FILL_W-1:0] fill_inc;
	logic [FILL_W-1:0] fill_n;
	logic [RUN_W-1:0]  vrun_n;
	logic [vssf_pkg::TMO_W-1:0] mrun_n;
	logic [W-1:0]      avg_n;
	logic [W-1:0]      avg_calc;
	logic              near;
	logic              drop;
	logic              store;

	logic [W:0]        sum_p [DEPTH/2];
	logic [W+1:0]      sum_q [DEPTH/4];
	logic [W+2:0]      sum_o [DEPTH/8];
	logic [SUM_W-1:0]  sum_all;

	// Compare the new value against the four newest entries
	always_comb begin
		near = 1'b0;
		for (int k = DEPTH - vssf_pkg::RUN_FOR_CHECK; k < DEPTH; k++) begin
			if (UPWARD) begin
				if ({1'b0, value} < ({1'b0, hist_q[k]} + JUMP)) near = 1'b1;
			end else begin
				if (({1'b0, value} + JUMP) > {1'b0, hist_q[k]}) near = 1'b1;
			end
		end
	end

	assign drop  = (vrun_q == RUN_CHECK) && !near;
	assign store = ctl.enable && ctl.good && !drop;

	// Shift the history by one, newest entry on top
	always_comb begin
		for (int k = 0; k < DEPTH - 1; k++) begin
			hist_n[k] = hist_q[k+1];
		end
		hist_n[DEPTH-1] = value;
	end

	// Adder tree over the shifted history
	always_comb begin
		for (int k = 0; k < DEPTH/2; k++) begin
			sum_p[k] = {1'b0, hist_n[2*k]} + {1'b0, hist_n[2*k+1]};
		end
		for (int k = 0; k < DEPTH/4; k++) begin
			sum_q[k] = {1'b0, sum_p[2*k]} + {1'b0, sum_p[2*k+1]};
		end
		for (int k = 0; k < DEPTH/8; k++) begin
			sum_o[k] = {1'b0, sum_q[2*k]} + {1'b0, sum_q[2*k+1]};
		end
		sum_all = {1'b0, sum_o[0]} + {1'b0, sum_o[1]};
	end

	assign fill_inc = (fill_q < FILL_FULL) ? fill_q + 1'b1 : fill_q;

	// Pick the mean over 2, 4, 8 or 16 newest entries, or zero below two entries
	always_comb begin
		if (fill_inc < FILL_W'(2)) begin
			avg_calc = '0;
		end else if (fill_inc < FILL_W'(4)) begin
			avg_calc = sum_p[DEPTH/2-1][W:1];
		end else if (fill_inc < FILL_W'(8)) begin
			avg_calc = sum_q[DEPTH/4-1][W+1:2];
		end else if (fill_inc < FILL_FULL) begin
			avg_calc = sum_o[DEPTH/8-1][W+2:3];
		end else begin
			avg_calc = sum_all[SUM_W-1:4];
		end
	end

	// Next state of run counters, fill and average
	always_comb begin
		fill_n = fill_q;
		vrun_n = vrun_q;
		mrun_n = mrun_q;
		avg_n  = avg_q;
		if (ctl.enable) begin
			if (!ctl.good) begin
				vrun_n = '0;
				if (mrun_q == timeout_limit) begin
					avg_n  = '0;
					fill_n = '0;
				end else begin
					mrun_n = mrun_q + 1'b1;
				end
			end else begin
				mrun_n = '0;
				if (vrun_q == RUN_CHECK) begin
					vrun_n = near ? RUN_CHECK : '0;
				end else begin
					vrun_n = vrun_q + 1'b1;
				end
				if (store) begin
					fill_n = fill_inc;
					avg_n  = avg_calc;
				end
			end
		end
	end

	assign avg_next = avg_n;

	// Hold state between processed transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				hist_q[k] <= '0;
			end
			fill_q <= '0;
			vrun_q <= '0;
			mrun_q <= '0;
			avg_q  <= '0;
		end else begin
			if (store) begin
				for (int k = 0; k < DEPTH; k++) begin
					hist_q[k] <= hist_n[k];
				end
			end
			fill_q <= fill_n;
			vrun_q <= vrun_n;
			mrun_q <= mrun_n;
			avg_q  <= avg_n;
		end
	end

	`VSSF_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_FULL)
	`VSSF_ASSERT_NEXT(a_timeout_clear, clk, arst_n, ctl.enable && !ctl.good && (mrun_q == timeout_limit), (avg_q == '0) && (fill_q == '0))
	`VSSF_ASSERT_NEXT(a_drop_holds, clk, arst_n, ctl.enable && ctl.good && drop, $stable(avg_q) && $stable(fill_q) && (vrun_q == '0))

endmodule

FILE: rtl/vital_sign_smoothing_filter.sv
// Path: an input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while out_ready is high; the whole channel update,
// adder tree included, sits in one pass between the two registers.
// Reset (arst_n low, asynchronous): history, fill counts, run counters, averages and the
// decimation counter clear to zero, registers return to their defaults, both stages empty.
// ---------------------------------------------------------------------------
// Vital sign smoothing filter
// Decimates input, qualifies heart rate and oxygen estimates, smooths them and flags alarms.
// ---------------------------------------------------------------------------
`include "vital_sign_smoothing_filter_macros.svh"

module vital_sign_smoothing_filter #(
	parameter int unsigned HISTORY_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [vssf_pkg::VAL_W-1:0]  hr_value,
	input  logic                               hr_ok,
	input  logic signed [vssf_pkg::VAL_W-1:0]  spo2_value,
	input  logic                               spo2_ok,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [vssf_pkg::HR_W-1:0]          hr_average,
	output logic [vssf_pkg::SPO2_W-1:0]        spo2_average,
	output logic                               alarm,
	output logic                               updated,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vssf_pkg::IDX_W-1:0]         cfg_index,
	input  logic [vssf_pkg::DATA_W-1:0]        cfg_data
);

	localparam int unsigned HR_W   = vssf_pkg::HR_W;
	localparam int unsigned SPO2_W = vssf_pkg::SPO2_W;
	localparam int unsigned VAL_W  = vssf_pkg::VAL_W;

	vssf_pkg::cfg_t      cfg;
	vssf_pkg::chan_ctl_t hr_ctl;
	vssf_pkg::chan_ctl_t spo2_ctl;

	logic                     valid_s1;
	logic signed [VAL_W-1:0]  hr_value_s1;
	logic                     hr_ok_s1;
	logic signed [VAL_W-1:0]  spo2_value_s1;
	logic                     spo2_ok_s1;

	logic                     valid_s2;
	logic [HR_W-1:0]          hr_avg_s2;
	logic [SPO2_W-1:0]        spo2_avg_s2;
	logic                     alarm_s2;
	logic                     updated_s2;

	logic [vssf_pkg::DEC_W-1:0] dec_cnt_q;

	logic              advance;
	logic              process;
	logic              hr_good;
	logic              spo2_good;
	logic [HR_W-1:0]   hr_avg_next;
	logic [SPO2_W-1:0] spo2_avg_next;
	logic              alarm_next;

	vssf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the held transaction on when the result register is free or its result is taken
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign process  = dec_cnt_q > cfg.decimate_count;

	// Range qualification
	assign hr_good = hr_ok_s1
		&& (hr_value_s1 < $signed({3'b000, cfg.hr_max_valid}))
		&& (hr_value_s1 > $signed({3'b000, cfg.hr_min_valid}));
	assign spo2_good = spo2_ok_s1
		&& (spo2_value_s1 > $signed({1'b0, cfg.spo2_min_valid}));

	assign hr_ctl   = '{enable: advance && process, good: hr_good};
	assign spo2_ctl = '{enable: advance && process, good: spo2_good};

	vssf_channel #(
		.W      (HR_W),
		.DEPTH  (HISTORY_DEPTH),
		.UPWARD (1'b1)
	) u_hr (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (hr_ctl),
		.value         (hr_value_s1[HR_W-1:0]),
		.timeout_limit (cfg.timeout_limit),
		.avg_next      (hr_avg_next)
	);

	vssf_channel #(
		.W      (SPO2_W),
		.DEPTH  (HISTORY_DEPTH),
		.UPWARD (1'b0)
	) u_spo2 (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (spo2_ctl),
		.value         (spo2_value_s1[SPO2_W-1:0]),
		.timeout_limit (cfg.timeout_limit),
		.avg_next      (spo2_avg_next)
	);

	// Alarm against the updated averages
	assign alarm_next =
		((hr_avg_next != '0) && (hr_avg_next >= cfg.hr_alarm_max)) ||
		((spo2_avg_next != '0) &&
		 ((spo2_avg_next <= cfg.spo2_alarm_min) || (spo2_avg_next >= cfg.spo2_alarm_max)));

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hr_value_s1   <= hr_value;
			hr_ok_s1      <= hr_ok;
			spo2_value_s1 <= spo2_value;
			spo2_ok_s1    <= spo2_ok;
		end
	end

	// Decimation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_cnt_q <= '0;
		end else if (advance) begin
			dec_cnt_q <= process ? '0 : dec_cnt_q + 1'b1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hr_avg_s2   <= hr_avg_next;
			spo2_avg_s2 <= spo2_avg_next;
			alarm_s2    <= alarm_next;
			updated_s2  <= process;
		end
	end

	assign out_valid    = valid_s2;
	assign hr_average   = hr_avg_s2;
	assign spo2_average = spo2_avg_s2;
	assign alarm        = alarm_s2;
	assign updated      = updated_s2;

	`VSSF_ASSERT_NEXT(a_advance_fills, clk, arst_n, advance, valid_s2)
	`VSSF_ASSERT_SAME(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && valid_s2 && !out_ready)
	`VSSF_ASSERT_NEXT(a_skip_flag, clk, arst_n, advance && !process, !updated_s2 && (dec_cnt_q == $past(dec_cnt_q) + 1'b1))

endmodule
